>>> design/string_hash_bucket_collision_counter_macros.svh
// Assertion macros for the string hash bucket collision counter.
`ifndef STRING_HASH_BUCKET_COLLISION_COUNTER_MACROS_SVH
`define STRING_HASH_BUCKET_COLLISION_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SHBC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SHBC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/shbc_pkg.sv
// Shared types and constants for the string hash bucket collision counter.
package shbc_pkg;

    localparam int HASH_W          = 32;
    localparam int KEY_W           = 8;
    localparam int CNT_W           = 16;
    localparam int IDX_OUT_W       = 8;
    localparam int CFG_W           = 9;
    localparam int MODE_W          = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int MAX_BUCKETS_DEF = 256;

    // modulo unit: bits retired per cycle
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_CYCLES    = HASH_W / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = $clog2(MOD_CYCLES);

    localparam logic [HASH_W-1:0] SEED_DJB2 = 32'd5381;
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [CNT_W-1:0]  CNT_SAT   = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DJB2 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SDBM = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FNV  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_RST       = MODE_DJB2;
    localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = 9'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'd1;

    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key_byte;
        logic             last_byte;
    } shbc_in_t;

    typedef struct packed {
        logic [HASH_W-1:0]    hash_value;
        logic [IDX_OUT_W-1:0] bucket_index;
        logic                 collided;
        logic [CNT_W-1:0]     bucket_count;
        logic [CNT_W-1:0]     collision_total;
    } shbc_out_t;

endpackage

>>> design/string_hash_bucket_collision_counter.sv
// A key end's hash enters the modulo unit; then its bucket count is read from the RAM
//   and written back as the result is registered, later while a result is held.
// Inner bytes are taken while idle; a key end blocks requests until its result is
//   registered, due to the 4-bit/cycle modulo unit and the single-port histogram RAM.
// Clear request: zeroes all histogram entries, one per cycle, and the collision total.
// Reset: async active low; all histogram entries are cleared before in_ready rises.
`include "string_hash_bucket_collision_counter_macros.svh"

module string_hash_bucket_collision_counter #(
    parameter int MAX_BUCKETS = shbc_pkg::MAX_BUCKETS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  shbc_pkg::shbc_in_t             in_req,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output shbc_pkg::shbc_out_t            out_rsp,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [shbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [shbc_pkg::CFG_W-1:0]     cfg_wdata
);
    import shbc_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BUCKETS);
    localparam int SIZE_W = $clog2(MAX_BUCKETS + 1);

    // sequencer codes
    localparam logic [2:0] ST_CLEAR  = 3'd0;  // sweeping zeros into the histogram
    localparam logic [2:0] ST_IDLE   = 3'd1;  // taking requests
    localparam logic [2:0] ST_MOD    = 3'd2;  // bucket index being computed
    localparam logic [2:0] ST_UPDATE = 3'd3;  // bucket count read back, write and emit

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]  coll_reg, coll_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [MODE_W-1:0] hash_mode_reg;
    logic [CFG_W-1:0]  table_size_reg;
    logic              out_valid_reg, out_valid_next;
    shbc_out_t         out_rsp_reg, out_rsp_next;

    logic              in_accept;
    logic              key_step;
    logic              key_end;
    logic [HASH_W-1:0] fold_value;
    logic [SIZE_W-1:0] eff_size;
    logic              mod_busy;
    logic [SIZE_W-1:0] mod_rem;
    logic [IDX_W-1:0]  bucket_idx;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [CNT_W-1:0]  ram_rdata;

    logic              hit;
    logic [CNT_W-1:0]  cnt_upd;
    logic [CNT_W-1:0]  coll_upd;
    logic              out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign key_step  = in_accept && (in_req.op == OP_KEY);
    assign key_end   = key_step && in_req.last_byte;
    assign out_free  = !out_valid_reg || out_ready;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mode_reg  <= MODE_RST;
            table_size_reg <= TABLE_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HASH_MODE:  hash_mode_reg  <= cfg_wdata[MODE_W-1:0];
                CFG_TABLE_SIZE: table_size_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Size zero behaves as one; sizes past the histogram saturate to its depth.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > 32'(MAX_BUCKETS))
        begin
            eff_size = SIZE_W'(MAX_BUCKETS);
        end
        else
        begin
            eff_size = SIZE_W'(table_size_reg);
        end
    end

    // ---------------------------------------------------------------
    // Hash accumulator and modulo unit
    // ---------------------------------------------------------------
    shbc_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (key_step),
        .mode       (hash_mode_reg),
        .key_byte   (in_req.key_byte),
        .last_byte  (in_req.last_byte),
        .fold_value (fold_value)
    );

    // dividend is captured in a register, so the FNV multiply ends at a flop
    shbc_mod #(
        .DIV_W (SIZE_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (key_end),
        .dividend  (fold_value),
        .divisor   (eff_size),
        .busy      (mod_busy),
        .remainder (mod_rem)
    );

    // remainder is below the effective size, which is at most MAX_BUCKETS
    assign bucket_idx = IDX_W'(mod_rem);

    // ---------------------------------------------------------------
    // Histogram: one RAM, read-modify-write per key end. Only one key is
    // in flight, so the write-back always lands before the next read.
    // ---------------------------------------------------------------
    shbc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BUCKETS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (bucket_idx),
        .rdata (ram_rdata)
    );

    assign hit      = (ram_rdata != '0);
    assign cnt_upd  = (ram_rdata == CNT_SAT) ? ram_rdata : ram_rdata + 1'b1;
    assign coll_upd = (hit && coll_reg != CNT_SAT) ? coll_reg + 1'b1 : coll_reg;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        coll_next      = coll_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_addr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(MAX_BUCKETS - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept && in_req.op == OP_CLEAR)
                begin
                    coll_next     = '0;
                    clr_addr_next = '0;
                    state_next    = ST_CLEAR;
                end
                else if (key_end)
                begin
                    hash_next  = fold_value;
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if (!mod_busy)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // read data holds here until the result register frees up
                if (out_free)
                begin
                    ram_we                       = 1'b1;
                    ram_waddr                    = bucket_idx;
                    ram_wdata                    = cnt_upd;
                    coll_next                    = coll_upd;
                    out_valid_next               = 1'b1;
                    out_rsp_next.hash_value      = hash_reg;
                    out_rsp_next.bucket_index    = IDX_OUT_W'(bucket_idx);
                    out_rsp_next.collided        = hit;
                    out_rsp_next.bucket_count    = cnt_upd;
                    out_rsp_next.collision_total = coll_upd;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            coll_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            coll_reg      <= coll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg    <= hash_next;
        out_rsp_reg <= out_rsp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SHBC_ASSERT_IMP(a_ready_mod_idle, in_ready, !mod_busy,
        "request taken while modulo unit busy")
    `SHBC_ASSERT_NXT(a_clear_no_result, (state_reg == ST_CLEAR) && !out_valid_reg,
        !out_valid_reg, "result produced during clearing pass")
    `SHBC_ASSERT_IMP(a_update_nonzero, ram_we && (state_reg == ST_UPDATE),
        ram_wdata != '0, "bucket written back as zero on key end")
    `SHBC_ASSERT_NXT(a_coll_monotone, !(in_accept && in_req.op == OP_CLEAR),
        coll_reg >= $past(coll_reg), "collision total dropped without clear")

endmodule

>>> design/shbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/shbc_hash.sv
// Running 32-bit key hash: byte sum, djb2, sdbm or FNV-1a.
module shbc_hash (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [shbc_pkg::MODE_W-1:0]   mode,
    input  logic [shbc_pkg::KEY_W-1:0]    key_byte,
    input  logic                          last_byte,
    output logic [shbc_pkg::HASH_W-1:0]   fold_value
);
    import shbc_pkg::*;

    logic [HASH_W-1:0] running_hash_reg, running_hash_next;
    logic              at_key_start_reg, at_key_start_next;
    logic [HASH_W-1:0] seed;
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] b;

    always_comb
    begin
        unique case (mode)
            MODE_DJB2: seed = SEED_DJB2;
            MODE_FNV:  seed = FNV_BASIS;
            default:   seed = '0;
        endcase
    end

    assign h = at_key_start_reg ? seed : running_hash_reg;
    assign b = HASH_W'(key_byte);

    always_comb
    begin
        unique case (mode)
            MODE_SUM:  fold_value = h + b;
            MODE_DJB2: fold_value = (h << 5) + h + b;
            MODE_SDBM: fold_value = b + (h << 6) + (h << 16) - h;
            default:   fold_value = (h ^ b) * FNV_PRIME;
        endcase
    end

    // key end restarts at the seed of the next key
    always_comb
    begin
        running_hash_next = running_hash_reg;
        at_key_start_next = at_key_start_reg;
        if (step)
        begin
            running_hash_next = last_byte ? '0 : fold_value;
            at_key_start_next = last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
            at_key_start_reg <= 1'b1;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
            at_key_start_reg <= at_key_start_next;
        end
    end

endmodule

>>> design/shbc_mod.sv
// Iterative 32-bit modulo by a narrow divisor, MOD_STEP_BITS dividend bits per cycle.
module shbc_mod #(
    parameter int DIV_W = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [shbc_pkg::HASH_W-1:0]  dividend,
    input  logic [DIV_W-1:0]             divisor,
    output logic                         busy,
    output logic [DIV_W-1:0]             remainder
);
    import shbc_pkg::*;

    logic [HASH_W-1:0]    dividend_reg, dividend_next;
    logic [DIV_W-1:0]     divisor_reg, divisor_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIV_W:0]       r;
    logic [HASH_W-1:0]    d;

    // restoring steps: shift in one dividend bit, subtract when it fits
    always_comb
    begin
        r = {1'b0, rem_reg};
        d = dividend_reg;
        for (int k = 0; k < MOD_STEP_BITS; k++)
        begin
            r = {r[DIV_W-1:0], d[HASH_W-1]};
            d = d << 1;
            if (r >= {1'b0, divisor_reg})
            begin
                r = r - {1'b0, divisor_reg};
            end
        end
    end

    always_comb
    begin
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        if (start)
        begin
            dividend_next = dividend;
            divisor_next  = divisor;
            rem_next      = '0;
            cnt_next      = '0;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            dividend_next = d;
            rem_next      = r[DIV_W-1:0];
            cnt_next      = cnt_reg + 1'b1;
            busy_next     = (cnt_reg != MOD_CNT_W'(MOD_CYCLES - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule
